FILE: sv/ffbt_pkg.sv
// ----------------------------------------------------------------------------
// ffbt_pkg
// Shared widths, request and status codes and controller states of the
// first-fit bin table.
// ----------------------------------------------------------------------------
package ffbt_pkg;

	localparam int unsigned SLOTS_DEF = 256;

	localparam int REQ_W    = 2;
	localparam int SPACE_W  = 32;
	localparam int DISK_W   = 16;
	localparam int TSLOT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int RSLOT_W  = 8;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_LIVE  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEL,
		S_UP,
		S_ROOT,
		S_DESC,
		S_DISK,
		S_RESP
	} ctrl_state_t;

endpackage

FILE: sv/ffbt_req_if.sv
// ----------------------------------------------------------------------------
// ffbt_req_if
// Request channel: valid/ready handshake with insert, delete and search fields.
// ----------------------------------------------------------------------------
interface ffbt_req_if import ffbt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [SPACE_W-1:0]  free_space;
	logic [DISK_W-1:0]   disk_handle;
	logic [TSLOT_W-1:0]  target_slot;
	logic [SPACE_W-1:0]  wanted_size;

	modport source (
		output valid, req_type, free_space, disk_handle, target_slot, wanted_size,
		input  ready
	);
	modport sink (
		input  valid, req_type, free_space, disk_handle, target_slot, wanted_size,
		output ready
	);
endinterface

FILE: sv/ffbt_rsp_if.sv
// ----------------------------------------------------------------------------
// ffbt_rsp_if
// Response channel: valid/ready handshake with status, slot and disk handle.
// ----------------------------------------------------------------------------
interface ffbt_rsp_if import ffbt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [RSLOT_W-1:0]  result_slot;
	logic [DISK_W-1:0]   result_disk;

	modport source (
		output valid, status, result_slot, result_disk,
		input  ready
	);
	modport sink (
		input  valid, status, result_slot, result_disk,
		output ready
	);
endinterface

FILE: sv/ffbt_ram.sv
// ----------------------------------------------------------------------------
// ffbt_ram
// Simple dual-port synchronous RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ffbt_ram import ffbt_pkg::*; #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	parameter int unsigned AW    = 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/first_fit_bin_table.sv
// ----------------------------------------------------------------------------
// first_fit_bin_table
// Bin table in creation order with a max tree for first-fit search.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)  : one transaction per request; req_type selects insert,
//                  delete or first-fit search. ready is high while the
//                  controller is idle.
//   rsp  (source): exactly one transaction per request, in request order.
// Tree walk, with L = clog2(SLOTS) tree levels (8 for 256 slots): one tree
//   RAM access per level, up the tree for insert/delete, down the tree for
//   search, plus one slot RAM access.
// The block takes one request at a time; a new request is taken while the
//   previous response still sits in the output register.
// Reset: the table is empty right after reset, no clearing pass. Tree nodes
//   and slot entries at or beyond the fill count read as empty.
// Stall: a response waits in the output register while rsp.ready is low; the
//   next result then holds in the controller until the register drains.
// ----------------------------------------------------------------------------
module first_fit_bin_table import ffbt_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffbt_req_if.sink    req,
	ffbt_rsp_if.source  rsp
);

	localparam int unsigned L      = $clog2(SLOTS);
	localparam int unsigned LEAVES = 1 << L;
	localparam int unsigned TREE_N = 2 * LEAVES - 1;
	localparam int unsigned TIDX_W = L + 1;
	localparam int unsigned NF_W   = L + 1;
	localparam int unsigned LEV_W  = $clog2(L + 1);
	localparam int unsigned VAL_W  = SPACE_W + 1;
	localparam int unsigned SMEM_W = 1 + SPACE_W + DISK_W;
	localparam int unsigned TGX_W  = L + 1 + TSLOT_W;

	ctrl_state_t state_q, state_d;

	logic [NF_W-1:0]     nf_q;
	logic [LEV_W-1:0]    lev_q;
	logic [L-1:0]        pos_q;
	logic [VAL_W-1:0]    cur_q;
	logic [VAL_W-1:0]    w1_q;
	logic                rok_q;
	logic                ins_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [L-1:0]        res_slot_q;
	logic [DISK_W-1:0]   res_disk_q;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [RSLOT_W-1:0]  rsp_slot_q;
	logic [DISK_W-1:0]   rsp_disk_q;

	// tree RAM ports
	logic              t_we;
	logic [TIDX_W-1:0] t_waddr, t_raddr;
	logic [VAL_W-1:0]  t_wdata, t_rdata;
	logic              t_rok;

	// slot RAM ports: {live, space, disk}
	logic              s_we;
	logic [L-1:0]      s_waddr, s_raddr;
	logic [SMEM_W-1:0] s_wdata, s_rdata;

	logic [VAL_W-1:0]   tree_eff;
	logic [VAL_W-1:0]   parent_val;
	logic [LEV_W-1:0]   par_lev;
	logic [L-1:0]       par_pos;
	logic [L-1:0]       nf_slot;
	logic               table_full;
	logic [TGX_W-1:0]   tgt_ext;
	logic               tgt_ok;
	logic [L-1:0]       tgt_slot;
	logic               fits;
	logic [L-1:0]       choose;
	logic [L-1:0]       child_pos;
	logic               out_free;
	logic               accept;
	logic [L+RSLOT_W-1:0] slot_ext;

	function automatic logic [TIDX_W-1:0] node_idx(input logic [LEV_W-1:0] lv,
	                                               input logic [L-1:0] ps);
		return ((TIDX_W'(1) << lv) - TIDX_W'(1)) + TIDX_W'(ps);
	endfunction

	// A node is written once its leftmost leaf has been inserted.
	function automatic logic node_ok(input logic [LEV_W-1:0] lv,
	                                 input logic [L-1:0] ps,
	                                 input logic [NF_W-1:0] nf);
		logic [L-1:0] lo;
		lo = ps << (LEV_W'(L) - lv);
		return {1'b0, lo} < nf;
	endfunction

	ffbt_ram #(.WIDTH(VAL_W), .DEPTH(TREE_N), .AW(TIDX_W)) u_tree_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	ffbt_ram #(.WIDTH(SMEM_W), .DEPTH(SLOTS), .AW(L)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// Leaf values are space+1 for live slots, 0 for dead ones, so a search for
	// size zero finds the earliest live slot through the same tree.
	assign tree_eff   = rok_q ? t_rdata : '0;
	assign parent_val = (tree_eff > cur_q) ? tree_eff : cur_q;
	assign par_lev    = lev_q - LEV_W'(1);
	assign par_pos    = pos_q >> 1;
	assign nf_slot    = nf_q[L-1:0];
	assign table_full = nf_q >= NF_W'(SLOTS);
	assign tgt_ext    = {{(L + 1){1'b0}}, req.target_slot};
	assign tgt_ok     = tgt_ext < {{TSLOT_W{1'b0}}, nf_q};
	assign tgt_slot   = tgt_ext[L-1:0];
	assign fits       = tree_eff >= w1_q;
	assign choose     = fits ? pos_q : (pos_q | L'(1));
	assign child_pos  = choose << 1;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign accept     = req.valid && req.ready;
	assign slot_ext   = {{RSLOT_W{1'b0}}, res_slot_q};

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.result_slot = rsp_slot_q;
	assign rsp.result_disk = rsp_disk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		t_we    = 1'b0;
		t_waddr = '0;
		t_wdata = '0;
		t_raddr = '0;
		t_rok   = 1'b0;
		s_we    = 1'b0;
		s_waddr = '0;
		s_wdata = '0;
		s_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					case (req.req_type)
						REQ_INSERT: begin
							if (table_full) begin
								state_d = S_RESP;
							end else begin
								s_we    = 1'b1;
								s_waddr = nf_slot;
								s_wdata = {1'b1, req.free_space, req.disk_handle};
								t_we    = 1'b1;
								t_waddr = node_idx(LEV_W'(L), nf_slot);
								t_wdata = {1'b0, req.free_space} + VAL_W'(1);
								t_raddr = node_idx(LEV_W'(L), nf_slot ^ L'(1));
								t_rok   = node_ok(LEV_W'(L), nf_slot ^ L'(1), nf_q);
								state_d = S_UP;
							end
						end
						REQ_DELETE: begin
							if (tgt_ok) begin
								s_raddr = tgt_slot;
								state_d = S_DEL;
							end else begin
								state_d = S_RESP;
							end
						end
						REQ_SEARCH: begin
							t_raddr = '0;
							t_rok   = (nf_q != '0);
							state_d = S_ROOT;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_DEL: begin
				if (s_rdata[SMEM_W-1]) begin
					s_we    = 1'b1;
					s_waddr = pos_q;
					s_wdata = {1'b0, s_rdata[SMEM_W-2:0]};
					t_we    = 1'b1;
					t_waddr = node_idx(LEV_W'(L), pos_q);
					t_wdata = '0;
					t_raddr = node_idx(LEV_W'(L), pos_q ^ L'(1));
					t_rok   = node_ok(LEV_W'(L), pos_q ^ L'(1), nf_q);
					state_d = S_UP;
				end else begin
					state_d = S_RESP;
				end
			end
			S_UP: begin
				// sibling data arrives; write parent, fetch the parent's sibling
				t_we    = 1'b1;
				t_waddr = node_idx(par_lev, par_pos);
				t_wdata = parent_val;
				if (par_lev == '0) begin
					state_d = S_RESP;
				end else begin
					t_raddr = node_idx(par_lev, par_pos ^ L'(1));
					t_rok   = node_ok(par_lev, par_pos ^ L'(1), nf_q);
				end
			end
			S_ROOT: begin
				if (fits) begin
					t_raddr = node_idx(LEV_W'(1), '0);
					t_rok   = node_ok(LEV_W'(1), '0, nf_q);
					state_d = S_DESC;
				end else begin
					state_d = S_RESP;
				end
			end
			S_DESC: begin
				if (lev_q == LEV_W'(L)) begin
					s_raddr = choose;
					state_d = S_DISK;
				end else begin
					t_raddr = node_idx(lev_q + LEV_W'(1), child_pos);
					t_rok   = node_ok(lev_q + LEV_W'(1), child_pos, nf_q);
				end
			end
			S_DISK: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// fill count and read-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q  <= '0;
			rok_q <= 1'b0;
		end else begin
			rok_q <= t_rok;
			if (state_q == S_UP && par_lev == '0 && ins_q) begin
				nf_q <= nf_q + NF_W'(1);
			end
		end
	end

	// walk registers and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					w1_q  <= {1'b0, req.wanted_size} + VAL_W'(1);
					lev_q <= LEV_W'(L);
					case (req.req_type)
						REQ_INSERT: begin
							ins_q      <= 1'b1;
							cur_q      <= {1'b0, req.free_space} + VAL_W'(1);
							pos_q      <= nf_slot;
							res_disk_q <= '0;
							if (table_full) begin
								res_status_q <= ST_FULL;
								res_slot_q   <= '0;
							end else begin
								res_status_q <= ST_OK;
								res_slot_q   <= nf_slot;
							end
						end
						REQ_DELETE: begin
							ins_q      <= 1'b0;
							cur_q      <= '0;
							pos_q      <= tgt_slot;
							res_disk_q <= '0;
							if (tgt_ok) begin
								res_status_q <= ST_OK;
								res_slot_q   <= tgt_slot;
							end else begin
								res_status_q <= ST_NOT_LIVE;
								res_slot_q   <= '0;
							end
						end
						default: begin
							ins_q        <= 1'b0;
							res_status_q <= ST_NOT_FOUND;
							res_slot_q   <= '0;
							res_disk_q   <= '0;
						end
					endcase
				end
			end
			S_DEL: begin
				if (!s_rdata[SMEM_W-1]) begin
					res_status_q <= ST_NOT_LIVE;
					res_slot_q   <= '0;
				end
			end
			S_UP: begin
				cur_q <= parent_val;
				pos_q <= par_pos;
				lev_q <= par_lev;
			end
			S_ROOT: begin
				lev_q <= LEV_W'(1);
				pos_q <= '0;
			end
			S_DESC: begin
				if (lev_q == LEV_W'(L)) begin
					res_slot_q <= choose;
				end else begin
					lev_q <= lev_q + LEV_W'(1);
					pos_q <= child_pos;
				end
			end
			S_DISK: begin
				res_status_q <= ST_OK;
				res_disk_q   <= s_rdata[DISK_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= slot_ext[RSLOT_W-1:0];
			rsp_disk_q   <= res_disk_q;
		end
	end

endmodule

FILE: tb/sv/first_fit_bin_table_test.sv
// ----------------------------------------------------------------------------
// first_fit_bin_table_test
// Self-checking bench for the first-fit bin table. A short table of directed
// requests comes first: empty table, field extremes, double delete and the
// unused request code. About 1500 random requests follow, mostly searches;
// most deletes aim at live bins. Responses are checked against a row's fixed
// value where a directed row gives one, else against an in-bench bin table model.
// ----------------------------------------------------------------------------
module first_fit_bin_table_test;
	import ffbt_pkg::*;

	localparam int unsigned SLOTS       = SLOTS_DEF;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 500;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 24;

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic [SPACE_W-1:0] space;
		logic [DISK_W-1:0]  disk;
		logic [TSLOT_W-1:0] slot;
		logic [SPACE_W-1:0] wanted;
	} bin_req_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [RSLOT_W-1:0]  slot;
		logic [DISK_W-1:0]   disk;
	} bin_rsp_t;

	typedef struct {
		bin_req_t rq;
		bit       typed;
		bin_rsp_t rs;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ffbt_req_if req ();
	ffbt_rsp_if rsp ();

	first_fit_bin_table #(.SLOTS(SLOTS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// bin table model
	bit                 bin_live [SLOTS];
	logic [SPACE_W-1:0] bin_space [SLOTS];
	logic [DISK_W-1:0]  bin_disk [SLOTS];
	int unsigned        next_slot = 0;

	bin_rsp_t pending_rsp_q [$];
	int       fault_cnt = 0;
	int       send_idle_pct = 0;
	int       rcv_idle_pct = 0;
	bit       hold_pending = 1'b0;
	int       quiet_cycles = 0;

	function automatic bin_rsp_t predict_bin_rsp(input bin_req_t rq);
		bin_rsp_t r;
		r = '{status: ST_NOT_FOUND, slot: '0, disk: '0};
		case (rq.kind)
			REQ_INSERT: begin
				if (next_slot >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					bin_live[next_slot]  = 1'b1;
					bin_space[next_slot] = rq.space;
					bin_disk[next_slot]  = rq.disk;
					r.status = ST_OK;
					r.slot   = next_slot[RSLOT_W-1:0];
					next_slot++;
				end
			end
			REQ_DELETE: begin
				if (rq.slot >= SLOTS || !bin_live[rq.slot]) begin
					r.status = ST_NOT_LIVE;
				end else begin
					bin_live[rq.slot] = 1'b0;
					r.status = ST_OK;
					r.slot   = rq.slot;
				end
			end
			REQ_SEARCH: begin
				// lowest live slot that fits is the earliest-created fitting bin
				for (int s = 0; s < SLOTS; s++) begin
					if (bin_live[s] && bin_space[s] >= rq.wanted) begin
						r.status = ST_OK;
						r.slot   = s[RSLOT_W-1:0];
						r.disk   = bin_disk[s];
						break;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_live_slot();
		int start;
		int s;
		if (next_slot == 0)
			return -1;
		start = $urandom_range(next_slot - 1);
		for (int k = 0; k < next_slot; k++) begin
			s = (start + k) % next_slot;
			if (bin_live[s])
				return s;
		end
		return -1;
	endfunction

	function automatic bin_req_t random_bin_req();
		bin_req_t rq;
		int pick;
		int mode;
		int ls;
		rq.kind   = REQ_SEARCH;
		rq.space  = $urandom;
		rq.disk   = $urandom;
		rq.slot   = $urandom;
		rq.wanted = $urandom;
		pick = $urandom_range(99);
		if (pick < 20) begin
			rq.kind = REQ_INSERT;
			mode = $urandom_range(7);
			if (mode < 2)
				rq.space = $urandom_range(255);
			else if (mode == 2)
				rq.space = '1;
		end else if (pick < 32) begin
			rq.kind = REQ_DELETE;
			ls = pick_live_slot();
			if ($urandom_range(9) < 8 && ls >= 0)
				rq.slot = ls[TSLOT_W-1:0];
		end else if (pick < 95) begin
			ls = pick_live_slot();
			mode = $urandom_range(19);
			if (mode < 6 && ls >= 0)
				rq.wanted = bin_space[ls];
			else if (mode < 9 && ls >= 0)
				rq.wanted = bin_space[ls] + 1;
			else if (mode == 9 || mode == 10)
				rq.wanted = '0;
			else if (mode == 11)
				rq.wanted = '1;
			else if (mode < 16)
				rq.wanted = $urandom_range(255);
		end else begin
			rq.kind = REQ_UNUSED;
		end
		return rq;
	endfunction

	function automatic dir_row_t row(input logic [REQ_W-1:0] kind,
			input logic [SPACE_W-1:0] space, input logic [DISK_W-1:0] disk,
			input logic [TSLOT_W-1:0] slot, input logic [SPACE_W-1:0] wanted,
			input bit typed, input logic [STATUS_W-1:0] st,
			input logic [RSLOT_W-1:0] rslot, input logic [DISK_W-1:0] rdisk);
		dir_row_t d;
		d.rq    = '{kind: kind, space: space, disk: disk, slot: slot, wanted: wanted};
		d.typed = typed;
		d.rs    = '{status: st, slot: rslot, disk: rdisk};
		return d;
	endfunction

	task automatic note_fault(input string what);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want)
			note_fault($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	task automatic offer(input bin_req_t rq, input bit typed, input bin_rsp_t fixed);
		bin_rsp_t pr;
		req.valid       <= 1'b1;
		req.req_type    <= rq.kind;
		req.free_space  <= rq.space;
		req.disk_handle <= rq.disk;
		req.target_slot <= rq.slot;
		req.wanted_size <= rq.wanted;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pr = predict_bin_rsp(rq);
		pending_rsp_q.push_back(typed ? fixed : pr);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// response side: random stalls plus one long hold-off on request
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		bin_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp_q.size() == 0) begin
				note_fault($sformatf("unexpected response status %0d slot %0d disk 0x%0h",
					rsp.status, rsp.result_slot, rsp.result_disk));
			end else begin
				want = pending_rsp_q.pop_front();
				check_field("status", 16'(want.status), 16'(rsp.status));
				check_field("result_slot", 16'(want.slot), 16'(rsp.result_slot));
				check_field("result_disk", want.disk, rsp.result_disk);
			end
		end
	end

	// watchdog: ends the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("first_fit_bin_table_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t rows [$];
		bin_rsp_t none;
		none = '{status: ST_OK, slot: '0, disk: '0};
		req.valid       <= 1'b0;
		req.req_type    <= REQ_INSERT;
		req.free_space  <= '0;
		req.disk_handle <= '0;
		req.target_slot <= '0;
		req.wanted_size <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes, double delete, unused code
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, '1, 1, ST_NOT_FOUND, 0, 0));
		rows.push_back(row(REQ_DELETE, 0, 0, 0, 0, 1, ST_NOT_LIVE, 0, 0));
		rows.push_back(row(REQ_DELETE, 0, 0, '1, 0, 1, ST_NOT_LIVE, 0, 0));
		rows.push_back(row(REQ_UNUSED, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0));
		rows.push_back(row(REQ_INSERT, 0, 0, 0, 0, 1, ST_OK, 0, 0));
		rows.push_back(row(REQ_INSERT, '1, '1, '1, '1, 1, ST_OK, 1, 0));
		rows.push_back(row(REQ_INSERT, 1, 16'h1234, 0, 0, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, '1, '1, '1, 0, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, 1, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, '1, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_DELETE, 0, 0, 1, 0, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_DELETE, 0, 0, 1, 0, 1, ST_NOT_LIVE, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, '1, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, 1, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_DELETE, 0, 0, 0, 0, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, 0, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_INSERT, 32'h8000_0000, 16'h8000, 0, 0, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, 32'h8000_0001, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_SEARCH, 0, 0, 0, 32'h7fff_ffff, 0, ST_OK, 0, 0));
		rows.push_back(row(REQ_DELETE, 0, 0, '1, 0, 1, ST_NOT_LIVE, 0, 0));
		rows.push_back(row(REQ_UNUSED, '1, '1, '1, '1, 1, ST_NOT_FOUND, 0, 0));

		send_idle_pct = 32;
		rcv_idle_pct  = 49;
		foreach (rows[i])
			offer(rows[i].rq, rows[i].typed, rows[i].rs);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 49 : 0;
			rcv_idle_pct  = (phase == 0) ? 49 : (phase == 1) ? 32 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long response stall while requests keep coming
				if (phase == 0 && n == 120)
					hold_pending = 1'b1;
				offer(random_bin_req(), 1'b0, none);
			end
			// let all pending responses drain after each phase
			req.valid <= 1'b0;
			@(posedge clk);
			while (pending_rsp_q.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_cnt == 0 && pending_rsp_q.size() == 0)
			$display("first_fit_bin_table_test: done, clean");
		else
			$display("first_fit_bin_table_test: done, errors");
		$finish;
	end

endmodule
